// ===== src/cdq_pkg.sv =====
// Shared types and codes for the circular double-ended queue.
`default_nettype none

package cdq_pkg;

   // Operation codes carried in the mode field; codes six and seven are no-ops.
   localparam logic [2:0] MODE_PUSH_TAIL = 3'd0;
   localparam logic [2:0] MODE_PUSH_HEAD = 3'd1;
   localparam logic [2:0] MODE_POP_TAIL  = 3'd2;
   localparam logic [2:0] MODE_POP_HEAD  = 3'd3;
   localparam logic [2:0] MODE_READ      = 3'd4;
   localparam logic [2:0] MODE_WRITE     = 3'd5;

   // Status codes returned with every result.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_BADIDX = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  index;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic [1:0]  status;
      logic [8:0]  count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/cdq_ram.sv =====
// Element store: one write port and one registered read port.
`default_nettype none

module cdq_ram #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire [DATA_WIDTH-1:0]         wr_data,
   input  wire                          rd_en,
   input  wire [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the address being written in the same cycle returns the old
   // contents; the controller forwards around that case.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/circular_deque.sv =====
// Top level of the circular double-ended queue with its two-stage controller.
`default_nettype none

// Circular double-ended queue. Up to DEPTH elements of DATA_WIDTH bits sit in a
// single synchronous memory, located by a head pointer and an element count.
// Each request transfer names one operation (push or pop at either end, read
// or overwrite by logical index, where index 0 is the head element) and gives
// exactly one response transfer carrying a data value, a status code and the
// element count after the operation. A push into a full queue reports full,
// a pop of an empty queue reports empty, and an index at or beyond the count
// reports a bad index; none of these change the queue, and all return zero
// data. Request values are cut to DATA_WIDTH bits, and returned data is
// zero-extended or cut to the 32-bit field. Timing: a request is taken in the
// first stage, which decides the operation from the head and count registers
// and issues the memory read; the second stage then picks up the
// read data, performs the single memory write (push or overwrite) and loads
// the response register. A new request is accepted every cycle as long as
// the response side keeps draining; the one memory write port and one read
// port set that figure. When the response register is stalled, the request
// side stalls once the second stage is also occupied. A read that hits the
// entry being written by the previous operation is served from a forwarding
// register.
module circular_deque #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire                  clock,
   input  wire                  reset,

   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire cdq_pkg::req_type req_item,

   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output cdq_pkg::rsp_type     rsp_item
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > 8) ? CW : 8;

   // Adds two positions and wraps the sum into the circular store. Both
   // operands are below DEPTH, so one compare and subtract is enough.
   function automatic logic [AW-1:0] wrap_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
      logic [CW:0] sum;
      logic [CW:0] red;
      sum = {1'b0, a} + {1'b0, b};
      red = (sum >= (CW+1)'(DEPTH)) ? sum - (CW+1)'(DEPTH) : sum;
      return red[AW-1:0];
   endfunction

   // Queue pointers.
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // Second stage: one decided operation waiting for its read data.
   logic                  p_valid_ff, p_valid_in;
   logic                  p_wr_ff;
   logic                  p_use_val_ff;
   logic                  p_use_mem_ff;
   logic [AW-1:0]         p_slot_ff;
   logic [DATA_WIDTH-1:0] p_val_ff;
   logic [1:0]            p_status_ff;
   logic [8:0]            p_count_ff;
   logic                  fwd_ff;
   logic [DATA_WIDTH-1:0] fwd_data_ff;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   cdq_pkg::rsp_type      rsp_ff, rsp_in;

   // First-stage decisions.
   logic                  accept;
   logic                  out_free;
   logic                  advance;
   logic                  wr_c;
   logic                  use_val_c;
   logic                  use_mem_c;
   logic [AW-1:0]         slot_c;
   logic [1:0]            status_c;
   logic [IW-1:0]         idx_ext;
   logic [63:0]           val_wide;
   logic [DATA_WIDTH-1:0] val_c;
   logic [31:0]           count_wide;
   logic                  full_c;
   logic                  empty_c;
   logic                  bad_idx_c;

   // Second-stage data path.
   logic [DATA_WIDTH-1:0] rd_data;
   logic [DATA_WIDTH-1:0] mem_word;
   logic [DATA_WIDTH-1:0] result_word;
   logic [63:0]           result_wide;

   // The response register is free when empty or being transferred now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = p_valid_ff && out_free;
   assign req_stall = p_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign val_wide  = {32'b0, req_item.value};
   assign val_c     = val_wide[DATA_WIDTH-1:0];
   assign idx_ext   = IW'(req_item.index);
   assign full_c    = (count_ff == CW'(DEPTH));
   assign empty_c   = (count_ff == '0);
   assign bad_idx_c = (idx_ext >= IW'(count_ff));

   always_comb begin
      status_c  = cdq_pkg::STATUS_OK;
      wr_c      = 1'b0;
      use_val_c = 1'b0;
      use_mem_c = 1'b0;
      slot_c    = head_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      unique case (req_item.mode)
         cdq_pkg::MODE_PUSH_TAIL: begin
            if (full_c) begin
               status_c = cdq_pkg::STATUS_FULL;
            end else begin
               slot_c    = wrap_add(CW'(head_ff), count_ff);
               wr_c      = 1'b1;
               use_val_c = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         cdq_pkg::MODE_PUSH_HEAD: begin
            if (full_c) begin
               status_c = cdq_pkg::STATUS_FULL;
            end else begin
               slot_c    = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
               head_in   = slot_c;
               wr_c      = 1'b1;
               use_val_c = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         cdq_pkg::MODE_POP_TAIL: begin
            if (empty_c) begin
               status_c = cdq_pkg::STATUS_EMPTY;
            end else begin
               slot_c    = wrap_add(CW'(head_ff), count_ff - 1'b1);
               use_mem_c = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         cdq_pkg::MODE_POP_HEAD: begin
            if (empty_c) begin
               status_c = cdq_pkg::STATUS_EMPTY;
            end else begin
               slot_c    = head_ff;
               head_in   = wrap_add(CW'(head_ff), CW'(1));
               use_mem_c = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         cdq_pkg::MODE_READ: begin
            if (bad_idx_c) begin
               status_c = cdq_pkg::STATUS_BADIDX;
            end else begin
               slot_c    = wrap_add(CW'(head_ff), idx_ext[CW-1:0]);
               use_mem_c = 1'b1;
            end
         end
         cdq_pkg::MODE_WRITE: begin
            if (bad_idx_c) begin
               status_c = cdq_pkg::STATUS_BADIDX;
            end else begin
               slot_c    = wrap_add(CW'(head_ff), idx_ext[CW-1:0]);
               use_mem_c = 1'b1;
               wr_c      = 1'b1;
            end
         end
         default: begin
            // Unused codes: no change, zero data, status ok.
         end
      endcase
   end

   assign count_wide = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Second-stage occupancy follows the request and response transfers.
   always_comb begin
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (out_free) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   // The write of the operation in the second stage lands in the same cycle as
   // this read, so a matching address takes the written value instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         p_wr_ff      <= wr_c;
         p_use_val_ff <= use_val_c;
         p_use_mem_ff <= use_mem_c;
         p_slot_ff    <= slot_c;
         p_val_ff     <= val_c;
         p_status_ff  <= status_c;
         p_count_ff   <= count_wide[8:0];
         fwd_ff       <= p_valid_ff && p_wr_ff && (p_slot_ff == slot_c);
         fwd_data_ff  <= p_val_ff;
      end
   end

   cdq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (advance && p_wr_ff),
      .wr_addr (p_slot_ff),
      .wr_data (p_val_ff),
      .rd_en   (accept && use_mem_c),
      .rd_addr (slot_c),
      .rd_data (rd_data)
   );

   assign mem_word    = fwd_ff ? fwd_data_ff : rd_data;
   assign result_word = p_use_val_ff ? p_val_ff :
                        p_use_mem_ff ? mem_word : '0;
   assign result_wide = 64'(result_word);

   always_comb begin
      rsp_in.data_out = result_wide[31:0];
      rsp_in.status   = p_status_ff;
      rsp_in.count    = p_count_ff;
   end

   always_comb begin
      if (out_free) begin
         rsp_valid_in = p_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ===== verif/tb_circular_deque.sv =====
// Self-checking testbench for the circular double-ended queue.
`timescale 1ns / 100ps

module tb_circular_deque;

   // Capacity of the queue under test; the prediction wraps its pointers at this size.
   localparam int QUEUE_DEPTH = 256;

   // The two spare mode codes, which the block must treat as no-ops.
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // Random operations after the directed opening, not counting no-op codes.
   localparam int RANDOM_OPS = 450;

   // Cycles that the block may still need after the last response, and the watchdog.
   localparam int DRAIN_CYCLES = 8;
   localparam int WATCHDOG_NS  = 200000;

   // One planned request transfer. When settle is set, the request side holds
   // off until every response owed so far has come back.
   typedef struct {
      cdq_pkg::req_type item;
      bit               settle;
   } planned_op_type;

   // The planned stream is shaped in phases: fill the queue, poke it while
   // full, then drain it with mixed traffic.
   typedef enum {PHASE_FILL, PHASE_FULL, PHASE_DRAIN} plan_phase_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   cdq_pkg::req_type req_item  = '0;
   logic             req_stall;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cdq_pkg::rsp_type rsp_item;

   // Requests waiting to be driven, and responses predicted but not yet seen.
   planned_op_type   pending_ops[$];
   cdq_pkg::rsp_type expected_rsps[$];

   // Shadow copy of the queue, advanced once per accepted request.
   logic [31:0] shadow_store [QUEUE_DEPTH];
   logic [7:0]  shadow_head  = '0;
   logic [8:0]  shadow_count = '0;

   // Element count as the plan will leave it, used to aim indexes and phases.
   int plan_count = 0;

   int  req_gap         = 0;
   int  rsp_hold        = 0;
   bit  req_calm        = 1'b0;
   bit  rsp_calm        = 1'b0;
   int  req_done_count  = 0;
   int  rsp_done_count  = 0;
   int  mismatch_count  = 0;

   circular_deque #(
      .DEPTH      (QUEUE_DEPTH),
      .DATA_WIDTH (32)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one operation to the shadow queue and returns the response that
   // the block owes for it. Refused operations leave the shadow untouched and
   // return zero data; the count always reflects the state afterwards.
   function automatic cdq_pkg::rsp_type deque_apply(cdq_pkg::req_type op);
      cdq_pkg::rsp_type answer;
      logic [7:0]       slot;
      answer = '0;
      unique case (op.mode)
         cdq_pkg::MODE_PUSH_TAIL: begin
            if (shadow_count == QUEUE_DEPTH) begin
               answer.status = cdq_pkg::STATUS_FULL;
            end else begin
               slot = 8'(shadow_head + shadow_count);
               shadow_store[slot] = op.value;
               shadow_count = shadow_count + 1'b1;
               answer.data_out = op.value;
            end
         end
         cdq_pkg::MODE_PUSH_HEAD: begin
            if (shadow_count == QUEUE_DEPTH) begin
               answer.status = cdq_pkg::STATUS_FULL;
            end else begin
               // The head pointer steps back and wraps from zero to the top slot.
               shadow_head = shadow_head - 1'b1;
               shadow_store[shadow_head] = op.value;
               shadow_count = shadow_count + 1'b1;
               answer.data_out = op.value;
            end
         end
         cdq_pkg::MODE_POP_TAIL: begin
            if (shadow_count == 0) begin
               answer.status = cdq_pkg::STATUS_EMPTY;
            end else begin
               shadow_count = shadow_count - 1'b1;
               answer.data_out = shadow_store[8'(shadow_head + shadow_count)];
            end
         end
         cdq_pkg::MODE_POP_HEAD: begin
            if (shadow_count == 0) begin
               answer.status = cdq_pkg::STATUS_EMPTY;
            end else begin
               answer.data_out = shadow_store[shadow_head];
               shadow_head = shadow_head + 1'b1;
               shadow_count = shadow_count - 1'b1;
            end
         end
         cdq_pkg::MODE_READ: begin
            if ({1'b0, op.index} >= shadow_count) begin
               answer.status = cdq_pkg::STATUS_BADIDX;
            end else begin
               answer.data_out = shadow_store[8'(shadow_head + op.index)];
            end
         end
         cdq_pkg::MODE_WRITE: begin
            if ({1'b0, op.index} >= shadow_count) begin
               answer.status = cdq_pkg::STATUS_BADIDX;
            end else begin
               slot = 8'(shadow_head + op.index);
               answer.data_out = shadow_store[slot];
               shadow_store[slot] = op.value;
            end
         end
         default: begin
            // Spare codes do nothing and report success with zero data.
         end
      endcase
      answer.count = shadow_count;
      return answer;
   endfunction

   // Draws the idle cycles in front of the next transfer. Now and then a side
   // switches into a calm stretch in which it never idles.
   function automatic int draw_pause(inout bit calm);
      if ($urandom_range(0, 19) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : int'($urandom_range(0, 8));
   endfunction

   // Appends one request to the plan and tracks the count that it will leave.
   task automatic plan_op(logic [2:0] mode, logic [7:0] index, logic [31:0] value,
                          bit settle);
      planned_op_type op;
      op.item.mode  = mode;
      op.item.index = index;
      op.item.value = value;
      op.settle     = settle;
      pending_ops.push_back(op);
      if ((mode == cdq_pkg::MODE_PUSH_TAIL || mode == cdq_pkg::MODE_PUSH_HEAD)
          && plan_count < QUEUE_DEPTH) begin
         plan_count++;
      end else if ((mode == cdq_pkg::MODE_POP_TAIL || mode == cdq_pkg::MODE_POP_HEAD)
                   && plan_count > 0) begin
         plan_count--;
      end
   endtask

   // Mostly picks a position that holds an element; sometimes any index at all,
   // which lands out of range unless the queue is nearly full.
   function automatic logic [7:0] pick_index(int held);
      if (held > 0 && $urandom_range(0, 99) < 85) begin
         return 8'($urandom_range(0, held - 1));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Request driver. A transfer happens at an edge where valid is high and the
   // block does not stall; the next request then follows after a drawn number
   // of idle cycles. A stalled request is held unchanged.
   always @(posedge clock) begin
      bit launch;
      bit settled;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(deque_apply(req_item));
            req_done_count <= req_done_count + 1;
            req_gap = draw_pause(req_calm);
         end
         // Both counters are registered, so a request marked settle only goes
         // out once the channel is quiet and every owed response has arrived.
         settled = !req_valid && (req_done_count == rsp_done_count);
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (pending_ops.size() != 0 && (!pending_ops[0].settle || settled)) begin
               launch = 1'b1;
            end
         end
         if (launch) begin
            req_item <= pending_ops[0].item;
            void'(pending_ops.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            req_valid <= launch;
         end
      end
   end

   // Response monitor. Every response transfer is checked field by field
   // against the oldest prediction. The stall line is raised for a drawn
   // number of cycles after each transfer, whether or not a response waits.
   always @(posedge clock) begin
      cdq_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_done_count <= rsp_done_count + 1;
            if (expected_rsps.size() == 0) begin
               $error("response with nothing outstanding: data_out %0h status %0d count %0d",
                      rsp_item.data_out, rsp_item.status, rsp_item.count);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.data_out !== want.data_out) begin
                  $error("data_out: expected %0h, actual %0h", want.data_out, rsp_item.data_out);
                  mismatch_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  mismatch_count++;
               end
               if (rsp_item.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_item.count);
                  mismatch_count++;
               end
            end
            rsp_hold = draw_pause(rsp_calm);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Builds the whole request plan, releases reset, and waits for the queue to
   // answer everything before it reports the outcome.
   initial begin
      plan_phase_type phase;
      int             made;
      int             full_left;
      int             roll;
      int             cut_push;
      int             cut_pop;
      int             cut_read;
      logic [2:0]     mode;

      // Directed opening: refusals on an empty queue, the head pointer wrapping
      // below zero, extreme values, reads and overwrites at and past the ends,
      // both spare codes, and a drain back to empty.
      plan_op(cdq_pkg::MODE_POP_TAIL,  8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_POP_HEAD,  8'hFF, 32'hFFFF_FFFF, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_WRITE,     8'h00, 32'h1234_5678, 1'b0);
      plan_op(cdq_pkg::MODE_PUSH_HEAD, 8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_PUSH_TAIL, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      plan_op(cdq_pkg::MODE_PUSH_HEAD, 8'h80, 32'h8000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_PUSH_TAIL, 8'h01, 32'h0000_0001, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'h03, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'h04, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'hFF, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_WRITE,     8'h01, 32'hA5A5_A5A5, 1'b1);
      plan_op(cdq_pkg::MODE_WRITE,     8'h03, 32'h5A5A_5A5A, 1'b0);
      plan_op(cdq_pkg::MODE_WRITE,     8'hC8, 32'hDEAD_BEEF, 1'b0);
      plan_op(MODE_SPARE_LO,           8'h02, 32'h7FFF_FFFF, 1'b0);
      plan_op(MODE_SPARE_HI,           8'hFF, 32'hFFFF_FFFF, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'h01, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_POP_HEAD,  8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_POP_TAIL,  8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_POP_TAIL,  8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_POP_HEAD,  8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_POP_HEAD,  8'h00, 32'h0000_0000, 1'b0);
      plan_op(cdq_pkg::MODE_PUSH_TAIL, 8'h55, 32'hC0FF_EE00, 1'b0);
      plan_op(cdq_pkg::MODE_READ,      8'h00, 32'h0000_0000, 1'b0);

      // Random part. The fill phase is mostly pushes, so the queue reaches its
      // capacity and the head pointer wraps; a short burst then hits the full
      // queue with pushes, reads and overwrites at random indexes; the rest drains with mixed
      // traffic. Spare codes are sprinkled in and do not count toward the total.
      phase     = PHASE_FILL;
      made      = 0;
      full_left = 12;
      while (made < RANDOM_OPS) begin
         if ($urandom_range(0, 99) < 2) begin
            plan_op($urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO,
                    8'($urandom_range(0, 255)), $urandom, 1'b0);
            continue;
         end
         unique case (phase)
            PHASE_FILL: begin
               cut_push = 90; cut_pop = 93; cut_read = 97;
            end
            PHASE_FULL: begin
               cut_push = 40; cut_pop = 40; cut_read = 70;
            end
            default: begin
               cut_push = 10; cut_pop = 85; cut_read = 93;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < cut_push) begin
            mode = $urandom_range(0, 1) ? cdq_pkg::MODE_PUSH_HEAD : cdq_pkg::MODE_PUSH_TAIL;
         end else if (roll < cut_pop) begin
            mode = $urandom_range(0, 1) ? cdq_pkg::MODE_POP_HEAD : cdq_pkg::MODE_POP_TAIL;
         end else if (roll < cut_read) begin
            mode = cdq_pkg::MODE_READ;
         end else begin
            mode = cdq_pkg::MODE_WRITE;
         end
         plan_op(mode, pick_index(plan_count), $urandom, $urandom_range(0, 74) == 0);
         made++;
         if (phase == PHASE_FILL && plan_count == QUEUE_DEPTH) begin
            phase = PHASE_FULL;
         end else if (phase == PHASE_FULL) begin
            full_left--;
            if (full_left == 0) begin
               phase = PHASE_DRAIN;
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Polling on the falling edge sees every register settled from the last
      // rising edge, so the exit condition cannot race the driver or monitor.
      while (pending_ops.size() != 0 || req_valid || rsp_done_count < req_done_count) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost response ends the run as a failure.
   initial begin
      #(WATCHDOG_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
